// ===== design/cal_pkg.sv =====
// Shared types and constants for the cursor array list.
package cal_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int WORD_W    = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND = 2'd0,
        K_FIRST  = 2'd1,
        K_NEXT   = 2'd2,
        K_REMOVE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_NO_NEXT    = 3'd3,
        ST_NO_CURRENT = 3'd4
    } t_status;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             append_en;
        logic             remove_en;
        logic [CNT_W-1:0] count;     // entry count before the operation
        logic [IDX_W-1:0] rm_idx;    // entry being removed
    } t_cell_ctl;

endpackage

// ===== design/cal_cell.sv =====
// One list entry: loads an appended word or takes its upper neighbor's word on remove.
module cal_cell (
    input  logic                           i_clk,
    input  cal_pkg::t_cell_ctl             i_ctl,
    input  logic [cal_pkg::IDX_W-1:0]      i_pos,
    input  logic signed [cal_pkg::WORD_W-1:0] i_word,
    input  logic signed [cal_pkg::WORD_W-1:0] i_up_data,
    output logic signed [cal_pkg::WORD_W-1:0] o_data
);

    logic signed [cal_pkg::WORD_W-1:0] r_data;
    logic signed [cal_pkg::WORD_W-1:0] n_data;
    logic [cal_pkg::CNT_W-1:0]         w_pos_ext;
    logic                              w_load_new;
    logic                              w_shift;

    assign w_pos_ext  = cal_pkg::CNT_W'(i_pos);
    assign w_load_new = i_ctl.append_en && (w_pos_ext == i_ctl.count);
    // entries above the removed one move down by one
    assign w_shift    = i_ctl.remove_en && (i_pos >= i_ctl.rm_idx)
                        && ((w_pos_ext + 1'b1) < i_ctl.count);

    always_comb begin
        n_data = r_data;
        if (w_load_new) begin
            n_data = i_word;
        end else if (w_shift) begin
            n_data = i_up_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== design/cal_ctrl.sv =====
// Count and cursor state, operation decode and the registered result.
module cal_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  cal_pkg::t_kind                      i_kind,
    input  logic signed [cal_pkg::WORD_W-1:0]   i_rd_data,
    output logic [cal_pkg::IDX_W-1:0]           o_rd_idx,
    output cal_pkg::t_cell_ctl                  o_ctl,
    output logic                                o_strobe,
    output logic [cal_pkg::STATUS_W-1:0]        o_status,
    output logic signed [cal_pkg::WORD_W-1:0]   o_value_out,
    output logic [cal_pkg::OUT_CNT_W-1:0]       o_count
);

    logic [cal_pkg::CNT_W-1:0]          r_count, n_count;
    logic                               r_cur_valid, n_cur_valid;
    logic [cal_pkg::IDX_W-1:0]          r_cur_idx, n_cur_idx;
    logic                               r_strobe;
    cal_pkg::t_status                   r_status, n_status;
    logic signed [cal_pkg::WORD_W-1:0]  r_value, n_value;

    logic [cal_pkg::CNT_W-1:0]          w_nxt;
    logic                               w_append, w_remove;

    assign w_nxt = r_cur_valid ? (cal_pkg::CNT_W'(r_cur_idx) + 1'b1) : '0;

    always_comb begin
        case (i_kind)
            cal_pkg::K_FIRST:  o_rd_idx = '0;
            cal_pkg::K_NEXT:   o_rd_idx = w_nxt[cal_pkg::IDX_W-1:0];
            default:           o_rd_idx = r_cur_idx;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_cur_valid = r_cur_valid;
        n_cur_idx   = r_cur_idx;
        n_status    = cal_pkg::ST_OK;
        n_value     = '0;
        w_append    = 1'b0;
        w_remove    = 1'b0;
        case (i_kind)
            cal_pkg::K_APPEND: begin
                if (r_count >= cal_pkg::CNT_W'(cal_pkg::CAPACITY)) begin
                    n_status = cal_pkg::ST_FULL;
                end else begin
                    w_append = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            cal_pkg::K_FIRST: begin
                if (r_count == '0) begin
                    n_status = cal_pkg::ST_EMPTY;
                end else begin
                    n_cur_valid = 1'b1;
                    n_cur_idx   = '0;
                    n_value     = i_rd_data;
                end
            end
            cal_pkg::K_NEXT: begin
                if (w_nxt >= r_count) begin
                    n_status = cal_pkg::ST_NO_NEXT;
                end else begin
                    n_cur_valid = 1'b1;
                    n_cur_idx   = w_nxt[cal_pkg::IDX_W-1:0];
                    n_value     = i_rd_data;
                end
            end
            cal_pkg::K_REMOVE: begin
                if (!r_cur_valid || (cal_pkg::CNT_W'(r_cur_idx) >= r_count)) begin
                    n_status = cal_pkg::ST_NO_CURRENT;
                end else begin
                    w_remove = 1'b1;
                    n_value  = i_rd_data;
                    n_count  = r_count - 1'b1;
                    if (r_cur_idx == '0) begin
                        n_cur_valid = 1'b0;
                    end else begin
                        n_cur_idx = r_cur_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_status = cal_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        o_ctl.append_en = i_accept && w_append;
        o_ctl.remove_en = i_accept && w_remove;
        o_ctl.count     = r_count;
        o_ctl.rm_idx    = r_cur_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_cur_idx   <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= i_accept;
            if (i_accept) begin
                r_count     <= n_count;
                r_cur_valid <= n_cur_valid;
                r_cur_idx   <= n_cur_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_value_out = r_value;
    assign o_count     = cal_pkg::OUT_CNT_W'(r_count);

endmodule

// ===== design/cursor_array_list_core.sv =====
// Top level of the cursor array list: controller plus a row of entry cells.
//
//  channel   handshake              fields
//  command   start / busy           i_kind, i_value_in
//  result    o_strobe (one cycle)   o_status, o_value_out, o_count
//
// One word is taken per cycle; busy stays low.
// The result word shows with o_strobe in the cycle after the command is accepted.
// Append, read and remove-with-shift all finish in the cell row in that cycle.
// Synchronous active-low reset empties the list and clears the cursor.
// The receiver cannot stall; every result is taken in its strobe cycle.
module cursor_array_list_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cal_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [cal_pkg::WORD_W-1:0]   i_value_in,
    output logic                                o_strobe,
    output logic [cal_pkg::STATUS_W-1:0]        o_status,
    output logic signed [cal_pkg::WORD_W-1:0]   o_value_out,
    output logic [cal_pkg::OUT_CNT_W-1:0]       o_count
);

    logic                               w_accept;
    logic [cal_pkg::IDX_W-1:0]          w_rd_idx;
    cal_pkg::t_cell_ctl                 w_ctl;
    logic signed [cal_pkg::WORD_W-1:0]  w_data [cal_pkg::CAPACITY];
    logic signed [cal_pkg::WORD_W-1:0]  w_up   [cal_pkg::CAPACITY];
    logic signed [cal_pkg::WORD_W-1:0]  w_rd_data;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_rd_data = w_data[w_rd_idx];

    cal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind      (cal_pkg::t_kind'(i_kind)),
        .i_rd_data   (w_rd_data),
        .o_rd_idx    (w_rd_idx),
        .o_ctl       (w_ctl),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count     (o_count)
    );

    for (genvar g = 0; g < cal_pkg::CAPACITY; g++) begin : g_cell
        // the top cell has no upper neighbor; it never shifts
        if (g == cal_pkg::CAPACITY - 1) begin : g_top
            assign w_up[g] = '0;
        end else begin : g_mid
            assign w_up[g] = w_data[g+1];
        end

        cal_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_pos     (cal_pkg::IDX_W'(g)),
            .i_word    (i_value_in),
            .i_up_data (w_up[g]),
            .o_data    (w_data[g])
        );
    end

endmodule

// ===== design/cal_checker.sv =====
// Port-level checks for the cursor array list, bound to the top level.
module cal_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [cal_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [cal_pkg::WORD_W-1:0]   i_value_in,
    input  logic                                o_strobe,
    input  logic [cal_pkg::STATUS_W-1:0]        o_status,
    input  logic signed [cal_pkg::WORD_W-1:0]   o_value_out,
    input  logic [cal_pkg::OUT_CNT_W-1:0]       o_count
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("no result word after accepted command");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result word without a command");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_count <= cal_pkg::OUT_CNT_W'(cal_pkg::CAPACITY)))
        else $error("count beyond capacity");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != cal_pkg::ST_OK)) |-> (o_value_out == '0))
        else $error("refused operation returned a nonzero word");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == cal_pkg::ST_FULL))
            |-> (o_count == cal_pkg::OUT_CNT_W'(cal_pkg::CAPACITY)))
        else $error("full status with list not full");

endmodule

bind cursor_array_list_core cal_checker u_cal_checker (.*);

// ===== sim/tb_cursor_array_list_core.sv =====
// Self-checking testbench for cursor_array_list_core: directed and random commands.
`timescale 1ns / 1ps

module tb_cursor_array_list_core;
    import cal_pkg::*;

    localparam int TOTAL_RANDOM = 1130;
    localparam int CALM_TAIL    = 120;   // no random idle gaps before the final commands

    typedef struct {
        t_kind                     kind;
        logic signed [WORD_W-1:0]  value;
        bit                        drain;  // hold this word until all replies are in
    } list_cmd_t;

    typedef struct {
        t_status                   status;
        logic signed [WORD_W-1:0]  value;
        logic [OUT_CNT_W-1:0]      count;
    } list_reply_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [KIND_W-1:0]           i_kind = K_APPEND;
    logic signed [WORD_W-1:0]    i_value_in = '0;
    logic                        o_strobe;
    logic [STATUS_W-1:0]         o_status;
    logic signed [WORD_W-1:0]    o_value_out;
    logic [OUT_CNT_W-1:0]        o_count;

    list_cmd_t   cmd_queue[$];
    list_reply_t replies_due[$];
    int          total_cmds = 0;
    int          accepted_count = 0;
    int          error_count = 0;

    // shadow copy of the list
    logic signed [WORD_W-1:0] shadow_entries [CAPACITY];
    int                       shadow_count = 0;
    bit                       cursor_valid = 1'b0;
    int                       cursor_idx = 0;

    // sender idle control
    int gap_left = 0;
    bit idle_on = 1'b0;
    int mode_left = 40;

    cursor_array_list_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_value_in  (i_value_in),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count     (o_count)
    );

    always #4 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one list operation to the shadow state and queues the reply it must give.
    task automatic apply_list_op(input t_kind op, input logic signed [WORD_W-1:0] word);
        list_reply_t r;
        int          nxt_idx;
        r.status = ST_OK;
        r.value  = '0;
        case (op)
            K_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_count] = word;
                    shadow_count++;
                end
            end
            K_FIRST: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    cursor_valid = 1'b1;
                    cursor_idx   = 0;
                    r.value      = shadow_entries[0];
                end
            end
            K_NEXT: begin
                nxt_idx = cursor_valid ? cursor_idx + 1 : 0;
                if (nxt_idx >= shadow_count) begin
                    r.status = ST_NO_NEXT;
                end else begin
                    cursor_valid = 1'b1;
                    cursor_idx   = nxt_idx;
                    r.value      = shadow_entries[nxt_idx];
                end
            end
            default: begin
                if (!cursor_valid || cursor_idx >= shadow_count) begin
                    r.status = ST_NO_CURRENT;
                end else begin
                    r.value = shadow_entries[cursor_idx];
                    for (int i = cursor_idx; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                    // removing entry 0 leaves no current entry
                    if (cursor_idx == 0) cursor_valid = 1'b0;
                    else cursor_idx--;
                end
            end
        endcase
        r.count = shadow_count[OUT_CNT_W-1:0];
        replies_due.push_back(r);
    endtask

    task automatic add_cmd(input t_kind kind, input logic signed [WORD_W-1:0] value,
                           input bit drain = 1'b0);
        list_cmd_t c;
        c.kind  = kind;
        c.value = value;
        c.drain = drain;
        cmd_queue.push_back(c);
        total_cmds++;
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Driver: one word offered at a time, held until start && !busy at an edge.
    always @(posedge i_clk) begin
        bit        drive_start;
        list_cmd_t nxt;
        drive_start = start;
        if (!i_rst_n) begin
            drive_start = 1'b0;
        end else begin
            if (start && !busy) begin
                apply_list_op(t_kind'(i_kind), i_value_in);
                accepted_count++;
                drive_start = 1'b0;
                mode_left--;
                if (mode_left <= 0) begin
                    idle_on   = $urandom_range(0, 1);
                    mode_left = $urandom_range(20, 80);
                end
                if (idle_on && accepted_count < total_cmds - CALM_TAIL &&
                    $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 17);
            end
            if (!drive_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_queue.size() > 0 &&
                             !(cmd_queue[0].drain && replies_due.size() > 0)) begin
                    nxt = cmd_queue.pop_front();
                    i_kind      <= nxt.kind;
                    i_value_in  <= nxt.value;
                    drive_start = 1'b1;
                end
            end
        end
        start <= drive_start;
    end

    // Monitor: results cannot be held off, so every strobe is checked at its edge.
    always @(posedge i_clk) begin
        list_reply_t want;
        if (i_rst_n && o_strobe) begin
            if (replies_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result status=%0d value=%0d count=%0d",
                                        o_status, o_value_out, o_count));
            end else begin
                want = replies_due.pop_front();
                if (o_status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_value_out !== want.value)
                    flag_mismatch($sformatf("value %0d, want %0d", o_value_out, want.value));
                if (o_count !== want.count)
                    flag_mismatch($sformatf("count %0d, want %0d", o_count, want.count));
            end
        end
    end

    initial begin
        int n;
        int made;
        // directed: refusals on an empty list
        add_cmd(K_REMOVE, 32'h1234_5678);
        add_cmd(K_NEXT, '1);
        add_cmd(K_FIRST, 32'h8000_0000);
        // fill to capacity with extremes first, then one refused append
        add_cmd(K_APPEND, 32'h8000_0000);
        add_cmd(K_APPEND, 32'h7FFF_FFFF);
        add_cmd(K_APPEND, '0);
        add_cmd(K_APPEND, '1);
        for (int i = 4; i < CAPACITY; i++)
            add_cmd(K_APPEND, (i % 2) ? 32'hAAAA_5555 : 32'h5555_AAAA);
        add_cmd(K_APPEND, 32'h0BAD_F00D);
        // remove of entry 0 drops the cursor, next lands on the new entry 0;
        // the first word waits until every earlier reply is in
        add_cmd(K_FIRST, '0, 1'b1);
        add_cmd(K_REMOVE, '0);
        add_cmd(K_NEXT, '0);
        add_cmd(K_REMOVE, '0);
        add_cmd(K_REMOVE, '0);

        // random: mostly well-formed sequences, some noise
        made = 0;
        while (made < TOTAL_RANDOM) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        add_cmd(K_APPEND, pick_word(), made == 0 && i == 0);
                    made += n;
                end
                3, 4, 5: begin
                    // walk the list, removing now and then, running past the end
                    add_cmd(K_FIRST, $urandom, $urandom_range(0, 39) == 0);
                    n = $urandom_range(2, 18);
                    for (int i = 0; i < n; i++)
                        add_cmd(($urandom_range(0, 2) == 0) ? K_REMOVE : K_NEXT, $urandom);
                    made += n + 1;
                end
                6: begin
                    // empty the list
                    add_cmd(K_FIRST, $urandom);
                    add_cmd(K_REMOVE, $urandom);
                    for (int i = 0; i < CAPACITY; i++) begin
                        add_cmd(K_NEXT, $urandom);
                        add_cmd(K_REMOVE, $urandom);
                    end
                    made += 2 * CAPACITY + 2;
                end
                default: begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        add_cmd(t_kind'($urandom_range(0, 3)), pick_word());
                    made += n;
                end
            endcase
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_cmds || replies_due.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && replies_due.size() == 0) begin
            $display("cursor_array_list_core verification clean");
        end else begin
            $display("cursor_array_list_core verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("cursor_array_list_core verification failed");
        $finish;
    end

endmodule
